// File: rtl/prbs9_pkg.sv
// ----------------------------------------------------------------------------
// prbs9_pkg
// shared types and constants of the prbs9 bit error rate checker
// ----------------------------------------------------------------------------
package prbs9_pkg;

   localparam int unsigned SHIFT_BITS  = 9;
   localparam int unsigned CFG_BITS    = 16;
   localparam int unsigned REPORT_BITS = 32;
   localparam int unsigned RESYNC_BITS = 16;
   localparam int unsigned TAP_HI      = 8;
   localparam int unsigned TAP_LO      = 4;

   localparam logic [SHIFT_BITS-1:0] SEED_RESET      = 9'd1;
   localparam logic [CFG_BITS-1:0]   THRESHOLD_RESET = 16'd18;
   localparam logic [CFG_BITS-1:0]   WINDOW_RESET    = 16'd1000;
   localparam logic [CFG_BITS-1:0]   LIMIT_RESET     = 16'd18;

   typedef logic [SHIFT_BITS-1:0]  shift_type;
   typedef logic [CFG_BITS-1:0]    cfg_word_type;
   typedef logic [REPORT_BITS-1:0] total_type;
   typedef logic [RESYNC_BITS-1:0] resync_type;

   typedef enum logic [1:0] {
      CSR_SEED           = 2'd0,
      CSR_LOCK_THRESHOLD = 2'd1,
      CSR_WINDOW_LENGTH  = 2'd2,
      CSR_ERROR_LIMIT    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RESULT_HUNT  = 2'd0,
      RESULT_MATCH = 2'd1,
      RESULT_ERROR = 2'd2
   } result_code_type;

endpackage

// File: rtl/prbs9_req_if.sv
// ----------------------------------------------------------------------------
// prbs9_req_if
// received bit channel, one bit per word
// ----------------------------------------------------------------------------
interface prbs9_req_if;
   logic valid;
   logic ready;
   logic rx_bit;

   modport source (output valid, output rx_bit, input ready);
   modport sink   (input valid, input rx_bit, output ready);
endinterface

// File: rtl/prbs9_rsp_if.sv
// ----------------------------------------------------------------------------
// prbs9_rsp_if
// check result channel, status and counters per word
// ----------------------------------------------------------------------------
interface prbs9_rsp_if;
   import prbs9_pkg::*;

   logic            valid;
   logic            ready;
   result_code_type result_code;
   logic            is_locked;
   total_type       bit_total;
   total_type       error_total;
   resync_type      resync_total;

   modport source (output valid, output result_code, output is_locked,
                   output bit_total, output error_total, output resync_total,
                   input ready);
   modport sink   (input valid, input result_code, input is_locked,
                   input bit_total, input error_total, input resync_total,
                   output ready);
endinterface

// File: rtl/prbs9_ber_checker.sv
// ----------------------------------------------------------------------------
// prbs9_ber_checker
// checks received bits against a prbs9 sequence (x^9 + x^5 + 1), hunts for
// lock, counts bits, errors and loss of lock per error window
// ----------------------------------------------------------------------------
// the state update is a single registered pass; the result is registered too
// throughput: one word per cycle while no csr write or result stall holds it
// reset: synchronous; registers return to defaults, shift register to the seed
// and all counters and the lock flag clear
// ----------------------------------------------------------------------------
module prbs9_ber_checker #(
   parameter int unsigned TOTAL_COUNTER_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   prbs9_req_if.sink                     req_ch,
   prbs9_rsp_if.source                   rsp_ch,
   input  logic                          csr_write,
   input  prbs9_pkg::csr_index_type      csr_index,
   input  prbs9_pkg::cfg_word_type       csr_data
);
   import prbs9_pkg::*;

   typedef logic [TOTAL_COUNTER_BITS-1:0] count_type;

   cfg_word_type    cfg_threshold_ff;
   cfg_word_type    cfg_window_ff;
   cfg_word_type    cfg_limit_ff;

   shift_type       shift_reg_ff,    shift_reg_in;
   cfg_word_type    match_run_ff,    match_run_in;
   logic            lock_flag_ff,    lock_flag_in;
   cfg_word_type    window_count_ff, window_count_in;
   cfg_word_type    window_err_ff,   window_err_in;
   count_type       checked_ff,      checked_in;
   count_type       errors_ff,       errors_in;
   resync_type      resync_ff,       resync_in;

   logic            rsp_valid_ff;
   result_code_type code_ff,         code_in;
   logic            locked_ff;
   total_type       bit_total_ff;
   total_type       error_total_ff;
   resync_type      resync_total_ff;

   shift_type       state_cur;
   logic            expected;
   logic            bit_err;
   cfg_word_type    window_count_inc;
   cfg_word_type    window_err_inc;
   shift_type       seed_forced;
   logic            accept;

   assign accept         = req_ch.valid && req_ch.ready;
   assign req_ch.ready   = (!rsp_valid_ff || rsp_ch.ready) && !csr_write;
   assign state_cur      = (shift_reg_ff == '0) ? shift_type'(1) : shift_reg_ff;
   assign expected       = state_cur[TAP_HI] ^ state_cur[TAP_LO];
   assign bit_err        = expected != req_ch.rx_bit;
   assign seed_forced    = (csr_data[SHIFT_BITS-1:0] == '0) ? shift_type'(1)
                                                             : csr_data[SHIFT_BITS-1:0];

   always_comb begin
      shift_reg_in     = shift_reg_ff;
      match_run_in     = match_run_ff;
      lock_flag_in     = lock_flag_ff;
      window_count_in  = window_count_ff;
      window_err_in    = window_err_ff;
      checked_in       = checked_ff;
      errors_in        = errors_ff;
      resync_in        = resync_ff;
      code_in          = RESULT_HUNT;
      window_count_inc = window_count_ff + 1'b1;
      window_err_inc   = window_err_ff + cfg_word_type'(bit_err);
      if (lock_flag_ff) begin
         shift_reg_in    = {state_cur[SHIFT_BITS-2:0], expected};
         checked_in      = checked_ff + 1'b1;
         errors_in       = errors_ff + count_type'(bit_err);
         window_count_in = window_count_inc;
         window_err_in   = window_err_inc;
         if (window_count_inc >= cfg_window_ff) begin
            if (window_err_inc > cfg_limit_ff) begin
               lock_flag_in = 1'b0;
               match_run_in = '0;
               resync_in    = resync_ff + 1'b1;
            end
            window_count_in = '0;
            window_err_in   = '0;
         end
         code_in = bit_err ? RESULT_ERROR : RESULT_MATCH;
      end else begin
         match_run_in = bit_err ? '0 : match_run_ff + 1'b1;
         shift_reg_in = {state_cur[SHIFT_BITS-2:0], req_ch.rx_bit};
         if (match_run_in >= cfg_threshold_ff) begin
            lock_flag_in    = 1'b1;
            window_count_in = '0;
            window_err_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_threshold_ff <= THRESHOLD_RESET;
         cfg_window_ff    <= WINDOW_RESET;
         cfg_limit_ff     <= LIMIT_RESET;
         shift_reg_ff     <= SEED_RESET;
         match_run_ff     <= '0;
         lock_flag_ff     <= 1'b0;
         window_count_ff  <= '0;
         window_err_ff    <= '0;
         checked_ff       <= '0;
         errors_ff        <= '0;
         resync_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SEED:           shift_reg_ff     <= seed_forced;
               CSR_LOCK_THRESHOLD: cfg_threshold_ff <= csr_data;
               CSR_WINDOW_LENGTH:  cfg_window_ff    <= csr_data;
               CSR_ERROR_LIMIT:    cfg_limit_ff     <= csr_data;
               default: ;
            endcase
         end else if (accept) begin
            shift_reg_ff    <= shift_reg_in;
            match_run_ff    <= match_run_in;
            lock_flag_ff    <= lock_flag_in;
            window_count_ff <= window_count_in;
            window_err_ff   <= window_err_in;
            checked_ff      <= checked_in;
            errors_ff       <= errors_in;
            resync_ff       <= resync_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded with each accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff         <= code_in;
         locked_ff       <= lock_flag_in;
         bit_total_ff    <= REPORT_BITS'(checked_in);
         error_total_ff  <= REPORT_BITS'(errors_in);
         resync_total_ff <= resync_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_code  = code_ff;
   assign rsp_ch.is_locked    = locked_ff;
   assign rsp_ch.bit_total    = bit_total_ff;
   assign rsp_ch.error_total  = error_total_ff;
   assign rsp_ch.resync_total = resync_total_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write) |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_hunt_window_clear: assert property (@(posedge clock) disable iff (reset)
      !lock_flag_ff |-> (window_count_ff == '0 && window_err_ff == '0))
      else $error("window counters not clear while hunting");

   a_locked_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write && lock_flag_ff) |=>
         checked_ff == count_type'($past(checked_ff) + 1'b1))
      else $error("locked word not counted");

   a_locked_code: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write && !lock_flag_ff) |=> (code_ff == RESULT_HUNT))
      else $error("hunting word reported a locked code");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the prbs9 bit error rate checker: a short directed
// walk through lock, unlock, zero register and the register extremes, then
// phases of prbs9 traffic with injected errors, slips, zero runs and noise
// under random register settings; every result word is checked field by
// field against the plan's wanted status or a bit-true tracker of the
// checker's state, with random backpressure and gaps on both channels
// ----------------------------------------------------------------------------
module tb;
   import prbs9_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COUNTER_BITS = 32;
   localparam int unsigned PHASES       = 12;
   localparam int unsigned PHASE_WORDS  = 127;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   typedef struct packed {
      result_code_type code;
      logic            locked;
      total_type       bits;
      total_type       errs;
      resync_type      resyncs;
   } bert_status_type;

   typedef enum logic {ROW_CSR, ROW_RX} row_op_type;
   typedef enum logic [1:0] {RX_ZERO, RX_ONE, RX_GOOD, RX_BAD} rx_pick_type;

   typedef struct packed {
      row_op_type      op;
      csr_index_type   idx;
      cfg_word_type    value;
      rx_pick_type     pick;
      logic [3:0]      reps;
      logic            has_want;
      bert_status_type want;
   } plan_row_type;

   localparam bert_status_type NO_WANT = '0;
   localparam int unsigned PLAN_ROWS = 22;

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_RX,  CSR_SEED, 16'd0, RX_ONE,  4'd1, 1'b1, '{RESULT_HUNT, 1'b0, 0, 0, 0}},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_ZERO, 4'd1, 1'b1, '{RESULT_HUNT, 1'b0, 0, 0, 0}},
      '{ROW_CSR, CSR_LOCK_THRESHOLD, 16'd0, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_ZERO, 4'd1, 1'b1, '{RESULT_HUNT, 1'b1, 0, 0, 0}},
      '{ROW_CSR, CSR_WINDOW_LENGTH, 16'd0, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_ERROR_LIMIT, 16'd0, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_GOOD, 4'd1, 1'b1, '{RESULT_MATCH, 1'b1, 1, 0, 0}},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_BAD,  4'd1, 1'b1, '{RESULT_ERROR, 1'b0, 2, 1, 1}},
      '{ROW_CSR, CSR_LOCK_THRESHOLD, 16'hffff, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_SEED, 16'd0, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      // ten zeros while hunting: the ninth empties the register, the tenth starts from one
      '{ROW_RX,  CSR_SEED, 16'd0, RX_ZERO, 4'd10, 1'b1, '{RESULT_HUNT, 1'b0, 2, 1, 1}},
      '{ROW_CSR, CSR_SEED, 16'd511, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_LOCK_THRESHOLD, 16'd1, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_GOOD, 4'd1, 1'b1, '{RESULT_HUNT, 1'b1, 2, 1, 1}},
      '{ROW_CSR, CSR_WINDOW_LENGTH, 16'hffff, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_ERROR_LIMIT, 16'hffff, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_BAD,  4'd3, 1'b0, NO_WANT},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_GOOD, 4'd2, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_ERROR_LIMIT, 16'd1, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_CSR, CSR_WINDOW_LENGTH, 16'd2, RX_ZERO, 4'd0, 1'b0, NO_WANT},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_BAD,  4'd2, 1'b0, NO_WANT},
      '{ROW_RX,  CSR_SEED, 16'd0, RX_GOOD, 4'd2, 1'b0, NO_WANT}
   };

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_write;
   csr_index_type csr_index;
   cfg_word_type  csr_data;

   prbs9_req_if req_ch();
   prbs9_rsp_if rsp_ch();

   prbs9_ber_checker #(.TOTAL_COUNTER_BITS(COUNTER_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // tracker of the checker state
   shift_type               trk_reg;
   logic [15:0]             trk_run;
   logic                    trk_locked;
   logic [15:0]             trk_win_bits;
   logic [15:0]             trk_win_errs;
   logic [COUNTER_BITS-1:0] trk_checked;
   logic [COUNTER_BITS-1:0] trk_errors;
   resync_type              trk_resyncs;
   cfg_word_type            lock_need;
   cfg_word_type            window_len;
   cfg_word_type            error_cap;

   shift_type       pattern_reg;
   bert_status_type expected_status[$];
   int unsigned     mismatches  = 0;
   int unsigned     cycle_count = 0;
   logic            gaps_on     = 1'b1;
   logic            stalls_on   = 1'b1;

   function automatic bert_status_type bert_track(input logic rx);
      shift_type       cur;
      logic            gen;
      bert_status_type st;
      cur = (trk_reg == '0) ? shift_type'(1) : trk_reg;
      gen = cur[TAP_HI] ^ cur[TAP_LO];
      st.code = RESULT_HUNT;
      if (trk_locked) begin
         trk_reg = {cur[SHIFT_BITS-2:0], gen};
         trk_checked++;
         trk_win_bits++;
         if (rx != gen) begin
            trk_errors++;
            trk_win_errs++;
         end
         if (trk_win_bits >= window_len) begin
            if (trk_win_errs > error_cap) begin
               trk_locked = 1'b0;
               trk_run = '0;
               trk_resyncs++;
            end
            trk_win_bits = '0;
            trk_win_errs = '0;
         end
         st.code = (rx != gen) ? RESULT_ERROR : RESULT_MATCH;
      end else begin
         trk_run = (rx == gen) ? trk_run + 1'b1 : '0;
         trk_reg = {cur[SHIFT_BITS-2:0], rx};
         if (trk_run >= lock_need) begin
            trk_locked = 1'b1;
            trk_win_bits = '0;
            trk_win_errs = '0;
         end
      end
      st.locked  = trk_locked;
      st.bits    = total_type'(trk_checked);
      st.errs    = total_type'(trk_errors);
      st.resyncs = trk_resyncs;
      return st;
   endfunction

   // transmit side pattern generator
   function automatic logic pattern_next();
      logic gen;
      gen = pattern_reg[TAP_HI] ^ pattern_reg[TAP_LO];
      pattern_reg = {pattern_reg[SHIFT_BITS-2:0], gen};
      return gen;
   endfunction

   task automatic csr_put(input csr_index_type idx, input cfg_word_type value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_SEED: begin
            trk_reg = (value[SHIFT_BITS-1:0] == '0) ? shift_type'(1) : value[SHIFT_BITS-1:0];
         end
         CSR_LOCK_THRESHOLD: lock_need  = value;
         CSR_WINDOW_LENGTH:  window_len = value;
         CSR_ERROR_LIMIT:    error_cap  = value;
         default: ;
      endcase
   endtask

   task automatic send_bit(input logic rx, input logic has_want,
                           input bert_status_type want);
      bert_status_type st;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.rx_bit <= rx;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      st = bert_track(rx);
      expected_status.push_back(has_want ? want : st);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // result side backpressure
   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      bert_status_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected word code %0d locked %0b bits %0d errs %0d resyncs %0d",
                     $time, rsp_ch.result_code, rsp_ch.is_locked, rsp_ch.bit_total,
                     rsp_ch.error_total, rsp_ch.resync_total);
            mismatches++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_ch.result_code !== want.code) begin
               $display("%0t: result_code expected %0d got %0d",
                        $time, want.code, rsp_ch.result_code);
               mismatches++;
            end
            if (rsp_ch.is_locked !== want.locked) begin
               $display("%0t: is_locked expected %0b got %0b",
                        $time, want.locked, rsp_ch.is_locked);
               mismatches++;
            end
            if (rsp_ch.bit_total !== want.bits) begin
               $display("%0t: bit_total expected %0d got %0d",
                        $time, want.bits, rsp_ch.bit_total);
               mismatches++;
            end
            if (rsp_ch.error_total !== want.errs) begin
               $display("%0t: error_total expected %0d got %0d",
                        $time, want.errs, rsp_ch.error_total);
               mismatches++;
            end
            if (rsp_ch.resync_total !== want.resyncs) begin
               $display("%0t: resync_total expected %0d got %0d",
                        $time, want.resyncs, rsp_ch.resync_total);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      shift_type   cur;
      logic        rx;
      int unsigned sent;
      int unsigned seg_kind;
      int unsigned seg_len;
      int unsigned flip_permille;

      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_index     = CSR_SEED;
      csr_data      = '0;
      req_ch.valid  = 1'b0;
      req_ch.rx_bit = 1'b0;

      trk_reg      = SEED_RESET;
      trk_run      = '0;
      trk_locked   = 1'b0;
      trk_win_bits = '0;
      trk_win_errs = '0;
      trk_checked  = '0;
      trk_errors   = '0;
      trk_resyncs  = '0;
      lock_need    = THRESHOLD_RESET;
      window_len   = WINDOW_RESET;
      error_cap    = LIMIT_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (PLAN[r]) begin
         if (PLAN[r].op == ROW_CSR) begin
            drain();
            csr_put(PLAN[r].idx, PLAN[r].value);
         end else begin
            for (int n = 0; n < PLAN[r].reps; n++) begin
               cur = (trk_reg == '0) ? shift_type'(1) : trk_reg;
               case (PLAN[r].pick)
                  RX_ZERO: rx = 1'b0;
                  RX_ONE:  rx = 1'b1;
                  RX_GOOD: rx = cur[TAP_HI] ^ cur[TAP_LO];
                  default: rx = ~(cur[TAP_HI] ^ cur[TAP_LO]);
               endcase
               send_bit(rx, PLAN[r].has_want, PLAN[r].want);
            end
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         gaps_on   = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
         stalls_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);

         case ($urandom_range(0, 7))
            0:       csr_put(CSR_SEED, 16'd0);
            1:       csr_put(CSR_SEED, 16'd511);
            default: csr_put(CSR_SEED, cfg_word_type'($urandom_range(1, 510)));
         endcase
         case ($urandom_range(0, 15))
            0:       csr_put(CSR_LOCK_THRESHOLD, 16'd0);
            1:       csr_put(CSR_LOCK_THRESHOLD, 16'd1);
            2:       csr_put(CSR_LOCK_THRESHOLD, 16'hffff);
            default: csr_put(CSR_LOCK_THRESHOLD, cfg_word_type'($urandom_range(2, 30)));
         endcase
         case ($urandom_range(0, 7))
            0:       csr_put(CSR_WINDOW_LENGTH, 16'd0);
            1:       csr_put(CSR_WINDOW_LENGTH, 16'd1);
            2:       csr_put(CSR_WINDOW_LENGTH, 16'hffff);
            3:       csr_put(CSR_WINDOW_LENGTH, 16'd1000);
            default: csr_put(CSR_WINDOW_LENGTH, cfg_word_type'($urandom_range(2, 80)));
         endcase
         case ($urandom_range(0, 7))
            0:       csr_put(CSR_ERROR_LIMIT, 16'd0);
            1:       csr_put(CSR_ERROR_LIMIT, 16'hffff);
            default: csr_put(CSR_ERROR_LIMIT, cfg_word_type'($urandom_range(0, 6)));
         endcase

         case ($urandom_range(0, 3))
            0:       flip_permille = 0;
            1:       flip_permille = 5;
            2:       flip_permille = 60;
            default: flip_permille = 300;
         endcase
         pattern_reg = shift_type'($urandom_range(1, 511));

         sent = 0;
         while (sent < PHASE_WORDS) begin
            seg_kind = $urandom_range(0, 9);
            seg_len  = $urandom_range(4, 40);
            // slip: drop pattern bits to misalign the sequence and provoke a loss of lock
            if (seg_kind == 9) begin
               repeat ($urandom_range(1, 8)) void'(pattern_next());
            end
            for (int n = 0; n < seg_len && sent < PHASE_WORDS; n++) begin
               case (seg_kind)
                  7:       rx = 1'($urandom_range(0, 1));
                  8:       rx = 1'b0;
                  default: rx = pattern_next() ^ ($urandom_range(0, 999) < flip_permille);
               endcase
               send_bit(rx, 1'b0, NO_WANT);
               sent++;
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/prbs9_pkg.sv
rtl/prbs9_req_if.sv
rtl/prbs9_rsp_if.sv
rtl/prbs9_ber_checker.sv
sim/tb.sv
